// ===== hdl/kpt_pkg.sv =====
// Shared types, codes and constants of the keyed priority table.
package kpt_pkg;

    // Most entries one report emits
    localparam int MAX_RESULTS = 16;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 32;
    localparam int SEV_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 56;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    // Pointer operations
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_CLR  = 3'd1;
    localparam logic [2:0] PTR_INC  = 3'd2;
    localparam logic [2:0] PTR_DEC  = 3'd3;
    localparam logic [2:0] PTR_FILL = 3'd4;

    // Result payload sources
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_RD   = 2'd1;
    localparam logic [1:0] SRC_ITEM = 2'd2;

    // One table entry, id in the low bits
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SEV_W-1:0]    sev;
        logic [ID_W-1:0]     id;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                capture;
        logic [2:0]          ptr_op;
        logic                rd_prev;
        logic                pos_mark;
        logic                top_mark;
        logic                shift_wr;
        logic                put_wr;
        logic                out_load;
        logic [1:0]          out_src;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             fill_zero;
        logic             fill_full;
        logic             ptr_last;
        logic             id_match;
        logic             grp_match;
        logic             grp_more;
        logic             shift_more;
        logic             emit_last;
        logic             out_free;
    } dp_stat_t;

endpackage

// ===== hdl/kpt_datapath.sv =====
// Datapath of the keyed priority table: entry memory, pointers and result register.
module kpt_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kpt_pkg::dp_cmd_t          cmd,
    output kpt_pkg::dp_stat_t         stat,
    input  logic [kpt_pkg::CMD_W-1:0] in_cmd,
    input  kpt_pkg::entry_t           in_entry,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [kpt_pkg::STATUS_W-1:0] out_status,
    output kpt_pkg::entry_t           out_entry,
    output logic                      out_last
);
    import kpt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    entry_t            mem_reg [CAPACITY];
    entry_t            rd_data_reg;
    entry_t            item_reg;
    logic [CMD_W-1:0]  item_cmd_reg;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    logic [CW-1:0]     ptr_reg;
    logic [CW-1:0]     ptr_next;
    logic [CW-1:0]     pos_reg;
    logic              pos_found_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SEV_W-1:0]  top_reg;
    logic [CW-1:0]     ptr_plus;
    logic [CW-1:0]     ptr_minus;
    logic [CW-1:0]     rd_addr;
    logic              sev_gt;
    logic              out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    entry_t            out_entry_reg;
    logic              out_last_reg;
    entry_t            out_src_data;

    assign ptr_plus  = ptr_reg + CW'(1);
    assign ptr_minus = ptr_reg - CW'(1);
    assign rd_addr   = cmd.rd_prev ? ptr_minus : ptr_reg;
    assign sev_gt    = rd_data_reg.sev > item_reg.sev;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr[AW-1:0]];
        if (cmd.shift_wr)
        begin
            mem_reg[ptr_reg[AW-1:0]] <= rd_data_reg;
        end
        else if (cmd.put_wr)
        begin
            mem_reg[pos_reg[AW-1:0]] <= item_reg;
        end
    end

    // Hold the item under work
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg     <= in_entry;
            item_cmd_reg <= in_cmd;
        end
    end

    // Next pointer value
    always_comb
    begin
        case (cmd.ptr_op)
            PTR_CLR:  ptr_next = '0;
            PTR_INC:  ptr_next = ptr_plus;
            PTR_DEC:  ptr_next = ptr_minus;
            PTR_FILL: ptr_next = fill_reg;
            default:  ptr_next = ptr_reg;
        endcase
    end

    assign fill_next = cmd.put_wr ? fill_reg + CW'(1) : fill_reg;

    // Fill count, scan pointer, insert position and report group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            pos_found_reg <= 1'b0;
            cnt_reg       <= '0;
            top_reg       <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            if (cmd.capture)
            begin
                pos_reg       <= fill_reg;
                pos_found_reg <= 1'b0;
            end
            else if (cmd.pos_mark && sev_gt && !pos_found_reg)
            begin
                pos_reg       <= ptr_reg;
                pos_found_reg <= 1'b1;
            end
            if (cmd.top_mark)
            begin
                if (ptr_reg == '0)
                begin
                    top_reg <= rd_data_reg.sev;
                end
                if (stat.grp_match)
                begin
                    cnt_reg <= ptr_plus;
                end
            end
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat.item_cmd   = item_cmd_reg;
        stat.fill_zero  = fill_reg == '0;
        stat.fill_full  = fill_reg == CW'(CAPACITY);
        stat.ptr_last   = ptr_plus == fill_reg;
        stat.id_match   = rd_data_reg.id == item_reg.id;
        stat.grp_match  = (ptr_reg == '0) || (rd_data_reg.sev == top_reg);
        stat.grp_more   = (ptr_plus < fill_reg) && (32'(ptr_plus) < MAX_RESULTS);
        stat.shift_more = ptr_reg > pos_reg;
        stat.emit_last  = ptr_plus == cnt_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Pick the payload of the next result
    always_comb
    begin
        case (cmd.out_src)
            SRC_RD:   out_src_data = rd_data_reg;
            SRC_ITEM: out_src_data = item_reg;
            default:  out_src_data = '0;
        endcase
    end

    // Result register: load a new transfer or drop the one taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_entry_reg  <= out_src_data;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_entry  = out_entry_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== hdl/kpt_ctrl.sv =====
// Controller of the keyed priority table: sequences scan, shift, insert and report steps.
module kpt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kpt_pkg::dp_stat_t stat,
    output kpt_pkg::dp_cmd_t  cmd
);
    import kpt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_MISS = 4'd2;
    localparam logic [3:0] S_SRD  = 4'd3;
    localparam logic [3:0] S_SEV  = 4'd4;
    localparam logic [3:0] S_FULL = 4'd5;
    localparam logic [3:0] S_HRD  = 4'd6;
    localparam logic [3:0] S_HEV  = 4'd7;
    localparam logic [3:0] S_PUT  = 4'd8;
    localparam logic [3:0] S_ERD  = 4'd9;
    localparam logic [3:0] S_EEV  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.ptr_op     = PTR_HOLD;
        cmd.out_src    = SRC_ZERO;
        cmd.out_status = ST_OK;
        cmd.out_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.ptr_op = PTR_CLR;
                case (stat.item_cmd) inside
                    CMD_INSERT: state_next = stat.fill_zero ? S_PUT : S_SRD;
                    CMD_LOOKUP, CMD_REPORT: state_next = stat.fill_zero ? S_MISS : S_SRD;
                    default: state_next = S_MISS;
                endcase
            end
            S_MISS:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_MISS;
                    state_next     = S_IDLE;
                end
            end
            S_SRD:
            begin
                state_next = S_SEV;
            end
            S_SEV:
            begin
                case (stat.item_cmd)
                    CMD_INSERT:
                    begin
                        cmd.pos_mark = 1'b1;
                        if (stat.id_match)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_src    = SRC_RD;
                                cmd.out_status = ST_DUP;
                                state_next     = S_IDLE;
                            end
                        end
                        else if (stat.ptr_last)
                        begin
                            if (stat.fill_full)
                            begin
                                state_next = S_FULL;
                            end
                            else
                            begin
                                cmd.ptr_op = PTR_FILL;
                                state_next = S_HRD;
                            end
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_INC;
                            state_next = S_SRD;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (stat.id_match)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_src  = SRC_RD;
                                state_next   = S_IDLE;
                            end
                        end
                        else if (stat.ptr_last)
                        begin
                            state_next = S_MISS;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_INC;
                            state_next = S_SRD;
                        end
                    end
                    default:
                    begin
                        // Grow the urgent group while severities agree
                        cmd.top_mark = 1'b1;
                        if (stat.grp_match && stat.grp_more)
                        begin
                            cmd.ptr_op = PTR_INC;
                            state_next = S_SRD;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_CLR;
                            state_next = S_ERD;
                        end
                    end
                endcase
            end
            S_FULL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_FULL;
                    state_next     = S_IDLE;
                end
            end
            S_HRD:
            begin
                // Read the entry below the hole, or stop at the insert position
                if (stat.shift_more)
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_HEV;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_HEV:
            begin
                cmd.shift_wr = 1'b1;
                cmd.ptr_op   = PTR_DEC;
                state_next   = S_HRD;
            end
            S_PUT:
            begin
                if (stat.out_free)
                begin
                    cmd.put_wr   = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_ITEM;
                    state_next   = S_IDLE;
                end
            end
            S_ERD:
            begin
                state_next = S_EEV;
            end
            S_EEV:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_RD;
                    cmd.out_last = stat.emit_last;
                    if (stat.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_INC;
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/keyed_priority_table.sv =====
// Top level of the keyed priority table: stream ports, controller and datapath.
//
// A table of up to CAPACITY entries (id, severity, handle) kept sorted by
// severity, lowest first and oldest first among equals. Each insert, lookup
// or report on a non-empty table walks the table one entry at a time: each
// step reads the entry memory and evaluates the registered read data in the
// next cycle. An insert scans for a duplicate id and the insert position,
// then shifts the entries above that position up one place and writes the
// new entry; an insert into a full table ends after the scan; a lookup scans
// until it hits or passes the last entry; a report examines entries to size
// the urgent group (the group and the first entry past it), then emits the
// group. An item on an empty table, or with an unused command, skips the
// scan. The result register lets the next item start while the last result
// still waits for the sink. No clearing pass follows reset: only the first
// fill-count entries are ever read.
module keyed_priority_table #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // patient_id[31:0], severity[39:32], record_handle[55:40]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // entry_id[31:0], entry_severity[39:32], entry_handle[55:40]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);
    import kpt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    entry_t   in_entry;
    entry_t   out_entry;
    logic     in_valid;

    // Unpack the input transfer
    assign in_entry.id     = s_axis_tdata[31:0];
    assign in_entry.sev    = s_axis_tdata[39:32];
    assign in_entry.handle = s_axis_tdata[55:40];
    assign in_valid        = s_axis_tvalid;

    kpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kpt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (s_axis_tuser),
        .in_entry   (in_entry),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_entry  (out_entry),
        .out_last   (m_axis_tlast)
    );

    // Pack the result transfer
    assign m_axis_tdata = {out_entry.handle, out_entry.sev, out_entry.id};

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the keyed priority table stream block.
module testbench;

    import kpt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_WAIT = 100;

    // Command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [SEV_W-1:0]    sev;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } answer_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]    s_axis_tuser = CMD_INSERT;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                m_axis_tlast;

    // Shadow copy of the sorted entries, index 0 most urgent
    logic [ID_W-1:0]     shadow_id [TABLE_DEPTH];
    logic [SEV_W-1:0]    shadow_sev [TABLE_DEPTH];
    logic [HANDLE_W-1:0] shadow_handle [TABLE_DEPTH];
    int                  shadow_fill = 0;

    answer_t pending_answers [$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      steady_flow = 1'b0;

    keyed_priority_table #(.CAPACITY(TABLE_DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Position of an id in the shadow table, -1 when absent
    function automatic int find_entry(input logic [ID_W-1:0] id);
        for (int i = 0; i < shadow_fill; i++)
        begin
            if (shadow_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic void queue_answer(input logic [STATUS_W-1:0] status,
                                         input logic [ID_W-1:0] id,
                                         input logic [SEV_W-1:0] sev,
                                         input logic [HANDLE_W-1:0] handle,
                                         input logic last);
        answer_t a;
        a.status = status;
        a.id     = id;
        a.sev    = sev;
        a.handle = handle;
        a.last   = last;
        pending_answers.push_back(a);
    endfunction

    // Update the shadow table and queue the answers one command produces
    function automatic void predict_answer(input logic [CMD_W-1:0] cmd,
                                           input logic [ID_W-1:0] id,
                                           input logic [SEV_W-1:0] sev,
                                           input logic [HANDLE_W-1:0] handle);
        int hit;
        int pos;
        int group;
        hit = find_entry(id);
        case (cmd)
            CMD_INSERT:
            begin
                if (hit >= 0)
                    queue_answer(ST_DUP, shadow_id[hit], shadow_sev[hit],
                                 shadow_handle[hit], 1'b1);
                else if (shadow_fill >= TABLE_DEPTH)
                    queue_answer(ST_FULL, '0, '0, '0, 1'b1);
                else
                begin
                    // Place after every entry of equal or more urgent severity
                    pos = 0;
                    while (pos < shadow_fill && shadow_sev[pos] <= sev)
                        pos++;
                    for (int j = shadow_fill; j > pos; j--)
                    begin
                        shadow_id[j]     = shadow_id[j-1];
                        shadow_sev[j]    = shadow_sev[j-1];
                        shadow_handle[j] = shadow_handle[j-1];
                    end
                    shadow_id[pos]     = id;
                    shadow_sev[pos]    = sev;
                    shadow_handle[pos] = handle;
                    shadow_fill++;
                    queue_answer(ST_OK, id, sev, handle, 1'b1);
                end
            end
            CMD_LOOKUP:
            begin
                if (hit < 0)
                    queue_answer(ST_MISS, '0, '0, '0, 1'b1);
                else
                    queue_answer(ST_OK, shadow_id[hit], shadow_sev[hit],
                                 shadow_handle[hit], 1'b1);
            end
            CMD_REPORT:
            begin
                if (shadow_fill == 0)
                    queue_answer(ST_MISS, '0, '0, '0, 1'b1);
                else
                begin
                    group = 0;
                    while (group < shadow_fill && group < MAX_RESULTS &&
                           shadow_sev[group] == shadow_sev[0])
                        group++;
                    for (int i = 0; i < group; i++)
                        queue_answer(ST_OK, shadow_id[i], shadow_sev[i],
                                     shadow_handle[i], i + 1 == group);
                end
            end
            default:
                queue_answer(ST_MISS, '0, '0, '0, 1'b1);
        endcase
    endfunction

    // Wait a random gap, then present one command until it is taken
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [ID_W-1:0] id,
                             input logic [SEV_W-1:0] sev,
                             input logic [HANDLE_W-1:0] handle);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {handle, sev, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_answer(cmd, id, sev, handle);
    endtask

    // Hold the input off until every queued answer has come back
    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    function automatic logic [ID_W-1:0] stored_id();
        return shadow_id[$urandom_range(0, shadow_fill - 1)];
    endfunction

    function automatic logic [SEV_W-1:0] random_sev();
        if ($urandom_range(0, 4) == 0)
            return SEV_W'($urandom_range(0, 255));
        return SEV_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [SEV_W-1:0] any_sev();
        return SEV_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [HANDLE_W-1:0] any_handle();
        return HANDLE_W'($urandom_range(0, 65535));
    endfunction

    // Pick one command of mixed kinds; inserts weigh more while filling
    task automatic send_random_item(input int insert_weight);
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            steady_flow = !steady_flow;
        if (pick < insert_weight)
            send_item(CMD_INSERT, $urandom, random_sev(), any_handle());
        else if (pick < insert_weight + 10)
            send_item(CMD_INSERT, stored_id(), random_sev(), any_handle());
        else if (pick < insert_weight + 40)
            send_item(CMD_LOOKUP, stored_id(), any_sev(), any_handle());
        else if (pick < insert_weight + 52)
            send_item(CMD_LOOKUP, $urandom, any_sev(), any_handle());
        else if (pick < insert_weight + 56)
            send_item(CMD_UNUSED, $urandom, any_sev(), any_handle());
        else
            send_item(CMD_REPORT, $urandom, any_sev(), any_handle());
    endtask

    // Report, lookup and unused command before anything is stored
    task automatic test_empty_table();
        send_item(CMD_REPORT, 32'h0, 8'h00, 16'h0000);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_item(CMD_UNUSED, 32'h1234_5678, 8'h5A, 16'hA5A5);
    endtask

    // Field extremes, ordering among equal severities, duplicates and lookups
    task automatic test_entry_extremes();
        send_item(CMD_INSERT, 32'h0000_0000, 8'hFF, 16'h0000);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 8'h00, 16'hFFFF);
        send_item(CMD_INSERT, 32'h5A5A_A5A5, 8'h00, 16'h1234);
        send_item(CMD_INSERT, 32'h8000_0001, 8'h80, 16'h8001);
        send_item(CMD_INSERT, 32'h0000_0000, 8'h01, 16'h7777);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 16'h0000);
        send_item(CMD_LOOKUP, 32'h0000_0000, 8'hFF, 16'hFFFF);
        send_item(CMD_LOOKUP, 32'h8000_0001, 8'h00, 16'h0000);
        send_item(CMD_LOOKUP, 32'hDEAD_BEEF, 8'h00, 16'h0000);
        send_item(CMD_REPORT, 32'h0, 8'h00, 16'h0000);
        send_item(CMD_INSERT, 32'h0000_00FF, 8'h00, 16'h00FF);
        send_item(CMD_REPORT, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    endtask

    // Fill the table with random entries, mixed with queries
    task automatic test_fill_to_capacity();
        while (shadow_fill < TABLE_DEPTH)
            send_random_item(40);
    endtask

    // Full table: overflow and duplicate inserts, queries, group reports
    task automatic test_full_table();
        for (int n = 0; n < 110; n++)
            send_random_item(30);
        steady_flow = 1'b1;
        for (int n = 0; n < 30; n++)
            send_random_item(30);
        steady_flow = 1'b0;
        for (int n = 0; n < 80; n++)
            send_random_item(30);
    endtask

    // Sink side: random stall before taking each result
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = steady_flow ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest expected answer
    always @(posedge clk)
    begin
        answer_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result status %0d id %h", $time,
                         m_axis_tuser, m_axis_tdata[31:0]);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[31:0] !== want.id)
                begin
                    $display("%0t: entry_id expected %h actual %h", $time,
                             want.id, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[39:32] !== want.sev)
                begin
                    $display("%0t: entry_severity expected %h actual %h", $time,
                             want.sev, m_axis_tdata[39:32]);
                    error_count++;
                end
                if (m_axis_tdata[55:40] !== want.handle)
                begin
                    $display("%0t: entry_handle expected %h actual %h", $time,
                             want.handle, m_axis_tdata[55:40]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("keyed_priority_table regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_entry_extremes();
        drain_answers();
        test_fill_to_capacity();
        drain_answers();
        test_full_table();

        // Let the last answers come back, then allow for stray results
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("keyed_priority_table regression: pass");
        else
            $display("keyed_priority_table regression: fail");
        $finish;
    end

endmodule
